FILE: hdl/wdtr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wdtr_pkg: shared types and constants for the watchdog timer register block
// Request and register codes, key values, control bit positions and the
// request and response bundles passed between the top level and the core.
// ----------------------------------------------------------------------------
package wdtr_pkg;

  // Request types
  localparam logic [1:0] REQ_TICK  = 2'd0;
  localparam logic [1:0] REQ_READ  = 2'd1;
  localparam logic [1:0] REQ_WRITE = 2'd2;

  // Word register indexes
  localparam logic [2:0] REG_CTRL   = 3'd0;
  localparam logic [2:0] REG_LOAD   = 3'd1;
  localparam logic [2:0] REG_VALUE  = 3'd2;
  localparam logic [2:0] REG_KEY    = 3'd3;
  localparam logic [2:0] REG_STATUS = 3'd4;

  // Control register layout
  localparam int CTRL_W     = 3;
  localparam int CTRL_EN    = 0;
  localparam int CTRL_IE    = 1;
  localparam int CTRL_RE    = 2;

  // Keys and reset values
  localparam logic [31:0] FEED_KEY   = 32'h5A5A_5A5A;
  localparam logic [31:0] LOCK_KEY   = 32'h1ACC_E551;
  localparam logic [31:0] LOAD_RESET = 32'h0000_FFFF;

  // One incoming item
  typedef struct packed {
    logic [1:0]  req_type;
    logic [2:0]  reg_index;
    logic [31:0] wdata;
  } req_t;

  // One result item
  typedef struct packed {
    logic [31:0] read_data;
    logic        irq_line;
    logic        wdog_line;
    logic        reset_pulse;
  } rsp_t;

endpackage

FILE: hdl/wdtr_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wdtr_core: watchdog state and per-item update logic
// Holds control, load, elapsed count, timeout and lock. Given the registered
// item it computes the response and the next state, committed on fire.
// ----------------------------------------------------------------------------
module wdtr_core (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          fire,
  input  wdtr_pkg::req_t req,
  output wdtr_pkg::rsp_t rsp
);

  logic [wdtr_pkg::CTRL_W-1:0] ctrl_r, ctrl_nxt;
  logic [31:0]                 load_r, load_nxt;
  logic [31:0]                 elapsed_r, elapsed_nxt;
  logic                        timeout_r, timeout_nxt;
  logic                        lock_r, lock_nxt;

  logic [31:0] elapsed_inc;
  logic [31:0] value_rd;
  logic [31:0] rdata;
  logic        pulse;

  // saturating tick count
  assign elapsed_inc = (elapsed_r == '1) ? elapsed_r : elapsed_r + 32'd1;

  // remaining count as seen by a read of the value register
  always_comb begin
    if (!ctrl_r[wdtr_pkg::CTRL_EN] || (elapsed_r == '0)) begin
      value_rd = load_r;
    end else if (elapsed_r >= load_r) begin
      value_rd = '0;
    end else begin
      value_rd = load_r - elapsed_r;
    end
  end

  // next state and response
  always_comb begin
    ctrl_nxt    = ctrl_r;
    load_nxt    = load_r;
    elapsed_nxt = elapsed_r;
    timeout_nxt = timeout_r;
    lock_nxt    = lock_r;
    rdata       = '0;
    pulse       = 1'b0;
    case (req.req_type)
      wdtr_pkg::REQ_TICK: begin
        if (ctrl_r[wdtr_pkg::CTRL_EN]) begin
          elapsed_nxt = elapsed_inc;
          if (!timeout_r && (elapsed_inc >= load_r)) begin
            timeout_nxt = 1'b1;
            pulse       = ctrl_r[wdtr_pkg::CTRL_RE];
          end
        end
      end
      wdtr_pkg::REQ_READ: begin
        case (req.reg_index)
          wdtr_pkg::REG_CTRL:   rdata = {28'd0, lock_r, ctrl_r};
          wdtr_pkg::REG_LOAD:   rdata = load_r;
          wdtr_pkg::REG_VALUE:  rdata = value_rd;
          wdtr_pkg::REG_STATUS: rdata = {31'd0, timeout_r};
          default:              rdata = '0;
        endcase
      end
      wdtr_pkg::REQ_WRITE: begin
        case (req.reg_index)
          wdtr_pkg::REG_CTRL: begin
            if (!lock_r) begin
              ctrl_nxt = req.wdata[wdtr_pkg::CTRL_W-1:0];
              if (req.wdata[wdtr_pkg::CTRL_EN]) begin
                elapsed_nxt = '0;
              end
            end
          end
          wdtr_pkg::REG_LOAD: begin
            if (!lock_r) begin
              load_nxt = req.wdata;
            end
          end
          wdtr_pkg::REG_KEY: begin
            if (req.wdata == wdtr_pkg::FEED_KEY) begin
              timeout_nxt = 1'b0;
              elapsed_nxt = '0;
            end else if (req.wdata == wdtr_pkg::LOCK_KEY) begin
              lock_nxt = 1'b1;
            end
          end
          wdtr_pkg::REG_STATUS: begin
            if (req.wdata[0]) begin
              timeout_nxt = 1'b0;
            end
            elapsed_nxt = '0;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  // response levels are taken after the item
  always_comb begin
    rsp.read_data   = rdata;
    rsp.irq_line    = timeout_nxt & ctrl_nxt[wdtr_pkg::CTRL_IE];
    rsp.wdog_line   = timeout_nxt;
    rsp.reset_pulse = pulse;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r    <= '0;
      load_r    <= wdtr_pkg::LOAD_RESET;
      elapsed_r <= '0;
      timeout_r <= 1'b0;
      lock_r    <= 1'b0;
    end else if (fire) begin
      ctrl_r    <= ctrl_nxt;
      load_r    <= load_nxt;
      elapsed_r <= elapsed_nxt;
      timeout_r <= timeout_nxt;
      lock_r    <= lock_nxt;
    end
  end

  // lock is sticky until reset
  a_lock_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    lock_r |=> lock_r)
    else $error("lock flag cleared without reset");

  // locked control and load never change
  a_locked_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    lock_r |=> ($stable(ctrl_r) && $stable(load_r)))
    else $error("control or load changed while locked");

  // a reset pulse only comes with a fresh timeout
  a_pulse_fresh: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && rsp.reset_pulse) |-> (!timeout_r && timeout_nxt))
    else $error("reset pulse without new timeout");

  // timeout only sets on an enabled tick
  a_timeout_set: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && !timeout_r && timeout_nxt) |->
      (req.req_type == wdtr_pkg::REQ_TICK && ctrl_r[wdtr_pkg::CTRL_EN]))
    else $error("timeout set outside an enabled tick");

endmodule

FILE: hdl/watchdog_timer_regs_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// watchdog_timer_regs_top: watchdog timer with word register access
// Items are ticks, register reads or register writes; each gives one result
// item carrying read data and the interrupt, watchdog and reset levels.
// ----------------------------------------------------------------------------
//  channel | handshake           | payload
//  --------+---------------------+--------------------------------------------
//  in      | in_valid / in_ready | in_req_type, in_reg_index, in_wdata
//  out     | out_valid/out_ready | out_read_data, out_irq_line,
//          |                     | out_wdog_line, out_reset_pulse
//
//  One item per cycle sustained while out_ready is high; an accepted item
//  goes through the input register and then the output register, which
//  drives out_valid. The input register feeds the core; state commits as
//  the item enters the output register, so the next item sees it updated.
//  in_ready stays high while the output register is empty or being drained.
//  Synchronous active-low reset restores control 0, load 0xFFFF, count 0,
//  timeout and lock clear, and empties both stages.
// ----------------------------------------------------------------------------
module watchdog_timer_regs_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_req_type,
  input  logic [2:0]  in_reg_index,
  input  logic [31:0] in_wdata,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_read_data,
  output logic        out_irq_line,
  output logic        out_wdog_line,
  output logic        out_reset_pulse
);

  logic            in_vld_r;
  wdtr_pkg::req_t  req_r;
  logic            out_vld_r;
  wdtr_pkg::rsp_t  rsp_r;
  wdtr_pkg::rsp_t  rsp;
  logic            adv;

  // item moves from input register to output register
  assign adv      = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !in_vld_r || adv;

  // input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_r.req_type  <= in_req_type;
      req_r.reg_index <= in_reg_index;
      req_r.wdata     <= in_wdata;
    end
  end

  wdtr_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (adv),
    .req   (req_r),
    .rsp   (rsp)
  );

  // output stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rsp_r <= rsp;
    end
  end

  assign out_valid       = out_vld_r;
  assign out_read_data   = rsp_r.read_data;
  assign out_irq_line    = rsp_r.irq_line;
  assign out_wdog_line   = rsp_r.wdog_line;
  assign out_reset_pulse = rsp_r.reset_pulse;

  // interrupt and reset pulse both imply the watchdog level
  a_irq_wdog: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && (rsp_r.irq_line || rsp_r.reset_pulse)) |-> rsp_r.wdog_line)
    else $error("irq or reset pulse without watchdog level");

  // a held result is not overwritten
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !out_ready) |-> !adv)
    else $error("output register overwritten while stalled");

  // a pending input item stays until it advances
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_vld_r && !adv) |=> (in_vld_r && $stable(req_r)))
    else $error("pending item lost or changed");

endmodule
